// ===== design/bounded_lifo_stack_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BOUNDED_LIFO_STACK_TOP_DEFINES_SVH
`define BOUNDED_LIFO_STACK_TOP_DEFINES_SVH

// Property that holds in the same cycle as its trigger.
`define BLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property that holds in the cycle after its trigger.
`define BLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bls_pkg.sv =====
`default_nettype none
package bls_pkg;

  localparam int CapW = 5;
  localparam int FillOutW = 5;
  localparam int PeekW = 4;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef logic [CapW-1:0] cap_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_BOTTOM = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  // Shift command broadcast along the cell row.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/bls_if.sv =====
`default_nettype none
interface bls_req_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  bls_pkg::op_t                  operation;
  logic signed [DATA_WIDTH-1:0]  push_value;
  logic [bls_pkg::PeekW-1:0]     peek_depth;

  modport source (output valid, operation, push_value, peek_depth, input ready);
  modport sink   (input valid, operation, push_value, peek_depth, output ready);
endinterface

interface bls_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  read_value;
  bls_pkg::status_t              status;
  logic                          is_empty;
  logic                          is_full;
  logic [bls_pkg::FillOutW-1:0]  fill_count;

  modport source (output valid, read_value, status, is_empty, is_full, fill_count,
                  input ready);
  modport sink   (input valid, read_value, status, is_empty, is_full, fill_count,
                  output ready);
endinterface
`default_nettype wire

// ===== design/bls_cell.sv =====
`default_nettype none
module bls_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                        clk,
  input  bls_pkg::cell_ctrl_t        ctrl,
  input  wire  [DATA_WIDTH-1:0]      from_above,
  input  wire  [DATA_WIDTH-1:0]      from_below,
  output logic [DATA_WIDTH-1:0]      data
);
  import bls_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      data <= from_above;
    end else if (ctrl.pop) begin
      data <= from_below;
    end
  end

endmodule
`default_nettype wire

// ===== design/bounded_lifo_stack_top.sv =====
// Channel  Dir  Payload
// req      in   operation, push_value, peek_depth
// rsp      out  read_value, status, is_empty, is_full, fill_count
// cfg      in   cfg_we, cfg_data (capacity_in_use)
//
// One beat per cycle unless a result waits; each result appears in the cycle after
// its request beat. The row of cells shifts by one entry on each accepted push or
// pop; the top entry lives in cell 0, the bottom entry is mirrored in a register.
// Reset clears the fill level and output valid and sets capacity to 16.
// While a result waits with rsp.ready low, req.ready is low.
`default_nettype none
module bounded_lifo_stack_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            cfg_we,
  input  bls_pkg::cap_t  cfg_data,
  bls_req_if.sink        req,
  bls_rsp_if.source      rsp
);
  import bls_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > CapW) ? FW : CapW;
  localparam int PW = (FW > PeekW) ? FW : PeekW;
  localparam int PK = (DEPTH < (1 << PeekW)) ? DEPTH : (1 << PeekW);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  cap_t                    cap;
  logic [FW-1:0]           fill;
  logic [FW-1:0]           fill_next;
  logic [DATA_WIDTH-1:0]   bottom;
  logic [DATA_WIDTH-1:0]   cell_q [DEPTH];
  cell_ctrl_t              ctrl;

  logic                    accept;
  logic [CW-1:0]           eff_cap;
  logic                    full;
  logic                    empty;
  logic [DATA_WIDTH-1:0]   peek_val;
  logic [DATA_WIDTH-1:0]   value;
  status_t                 status;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CapReset;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  // Zero counts as one; anything above the row length saturates.
  always_comb begin
    eff_cap = (cap == '0) ? CW'(1) : CW'(cap);
    if (eff_cap > DepthC) begin
      eff_cap = DepthC;
    end
  end

  assign full  = CW'(fill) >= eff_cap;
  assign empty = (fill == '0);

  always_comb begin
    peek_val = cell_q[0];
    for (int i = 0; i < PK; i++) begin
      if (req.peek_depth == PeekW'(i)) begin
        peek_val = cell_q[i];
      end
    end
  end

  always_comb begin
    ctrl      = '0;
    fill_next = fill;
    value     = '0;
    status    = ST_OK;
    case (req.operation)
      OP_PUSH: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          ctrl.push = accept;
          fill_next = fill + FW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_UNDERFLOW;
          value  = '1;
        end else begin
          ctrl.pop  = accept;
          fill_next = fill - FW'(1);
          value     = cell_q[0];
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status = ST_UNDERFLOW;
          value  = '1;
        end else if (PW'(req.peek_depth) >= PW'(fill)) begin
          status = ST_BADPOS;
          value  = '1;
        end else begin
          value = peek_val;
        end
      end
      OP_BOTTOM: begin
        if (empty) begin
          status = ST_UNDERFLOW;
          value  = '1;
        end else begin
          value = bottom;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  generate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] above;
      logic [DATA_WIDTH-1:0] below;
      if (g == 0) begin : g_first
        assign above = req.push_value;
      end else begin : g_mid
        assign above = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign below = cell_q[g];
      end else begin : g_inner
        assign below = cell_q[g+1];
      end
      bls_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .from_above (above),
        .from_below (below),
        .data       (cell_q[g])
      );
    end
  endgenerate

  // Bottom entry is only ever written by a push onto an empty stack.
  always_ff @(posedge clk) begin
    if (ctrl.push && empty) begin
      bottom <= req.push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= value;
      rsp.status     <= status;
      rsp.is_empty   <= (fill_next == '0);
      rsp.is_full    <= CW'(fill_next) >= eff_cap;
      rsp.fill_count <= FillOutW'(fill_next);
    end
  end

endmodule
`default_nettype wire

// ===== design/bls_checker.sv =====
`default_nettype none
`include "bounded_lifo_stack_top_defines.svh"
module bls_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          req_valid,
  input wire                          req_ready,
  input wire                          rsp_valid,
  input wire                          rsp_ready,
  input wire [DATA_WIDTH-1:0]         rsp_read_value,
  input bls_pkg::status_t             rsp_status,
  input wire                          rsp_is_empty,
  input wire [bls_pkg::FillOutW-1:0]  rsp_fill_count
);
  import bls_pkg::*;

  `BLS_ASSERT_NEXT(a_rsp_held, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
  `BLS_ASSERT_NEXT(a_one_cycle, clk, rst, req_valid && req_ready, rsp_valid, "result missing")
  `BLS_ASSERT_NOW(a_err_value, clk, rst, rsp_valid && (rsp_status == ST_UNDERFLOW || rsp_status == ST_BADPOS), rsp_read_value == '1, "error value not all ones")
  `BLS_ASSERT_NOW(a_under_empty, clk, rst, rsp_valid && rsp_status == ST_UNDERFLOW, rsp_is_empty, "underflow on nonempty stack")
  `BLS_ASSERT_NOW(a_empty_flag, clk, rst, rsp_valid, rsp_is_empty == (rsp_fill_count == '0), "empty flag mismatch")

endmodule

bind bounded_lifo_stack_top bls_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bls_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .rsp_status     (rsp.status),
  .rsp_is_empty   (rsp.is_empty),
  .rsp_fill_count (rsp.fill_count)
);
`default_nettype wire
